[src/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_SUB    = 3'd1,
    CMD_MUL    = 3'd2,
    CMD_DIV    = 3'd3,
    CMD_GT     = 3'd4,
    CMD_GE     = 3'd5,
    CMD_EQ     = 3'd6,
    CMD_REDUCE = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZDEN = 2'd1,
    STAT_OVF  = 2'd2
  } status_t;

  // classified word waiting between front and back
  typedef struct packed {
    cmd_t        cmd;
    logic        err;
    logic        sa;
    logic        sb;
    logic        b_nz;
    logic [31:0] am;
    logic [31:0] adm;
    logic [31:0] bm;
    logic [31:0] bdm;
  } entry_t;

  // queue head handshake toward the back end
  typedef struct packed {
    logic   valid;
    entry_t data;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

[src/rau_if.sv]
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels carrying operand and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               cmp_true;
  logic [1:0]         status;
  modport source (output valid, res_num, res_den, cmp_true, status, input ready);
  modport sink   (input valid, res_num, res_den, cmp_true, status, output ready);
endinterface
`default_nettype wire

[src/rau_front.sv]
// ----------------------------------------------------------------------------
// rau_front
// Takes operand words, forms magnitudes and signs, flags zero denominators
// and zero divisors and holds the classified words in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_front (
  input  wire              clk,
  input  wire              rst_n,
  rau_in_if.sink           in_ch,
  output rau_pkg::q_head_t head,
  input  wire              pop
);
  import rau_pkg::*;

  entry_t     q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  entry_t     ent;
  logic       push;

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (~v + 32'd1) : v;
  endfunction

  // classify incoming word
  always_comb begin
    ent.cmd  = cmd_t'(in_ch.cmd);
    ent.am   = mag(in_ch.a_num);
    ent.adm  = mag(in_ch.a_den);
    ent.bm   = mag(in_ch.b_num);
    ent.bdm  = mag(in_ch.b_den);
    ent.b_nz = (ent.bm != 32'd0);
    ent.sa   = (in_ch.a_num[31] != in_ch.a_den[31]) && (ent.am != 32'd0);
    ent.sb   = (in_ch.b_num[31] != in_ch.b_den[31]) && ent.b_nz;
    ent.err  = (ent.adm == 32'd0)
            || ((ent.cmd != CMD_REDUCE) && (ent.bdm == 32'd0))
            || ((ent.cmd == CMD_DIV) && !ent.b_nz);
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (cnt_r != 2'd0);
  assign head.data   = q_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[src/rau_back.sv]
// ----------------------------------------------------------------------------
// rau_back
// Executes one queued word: serial cross products, combine, binary gcd,
// two parallel restoring divisions and the range check.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_back #(
  parameter int WORD_BITS = 32
) (
  input  wire              clk,
  input  wire              rst_n,
  input  rau_pkg::q_head_t head,
  output logic             pop,
  rau_out_if.source        out_ch
);
  import rau_pkg::*;

  localparam logic [63:0] LIM = 64'd1 << (WORD_BITS - 1);

  state_t      state_r, state_nxt;
  entry_t      e_r;
  logic [1:0]  step_r;
  logic [63:0] p_r [3];
  logic [31:0] opa, opb;
  logic [63:0] prod;
  logic [63:0] rm_r, rd_r, gx_r, gy_r, g_r, qn_r, qd_r;
  logic [63:0] remn_r, remd_r;
  logic [5:0]  k_r, cnt_r;
  logic        rs_r, cmp_r;
  logic        load_out;
  logic        out_valid_r;
  logic [31:0] res_num_r;
  logic [30:0] res_den_r;
  logic        cmp_true_r;
  status_t     status_r;
  logic        s2;
  logic [63:0] xs, ys;
  logic [64:0] tn, td;
  logic        fin_rs, ovf;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (head.valid) state_nxt = head.data.err ? ST_FIN : ST_MUL;
      ST_MUL:  if (step_r == 2'd2) state_nxt = ST_COMB;
      ST_COMB: state_nxt = (e_r.cmd == CMD_GT || e_r.cmd == CMD_GE || e_r.cmd == CMD_EQ)
                           ? ST_FIN : ST_GCD;
      ST_GCD:  if (gx_r == 64'd0) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 6'd63) state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    pop      = (state_r == ST_IDLE) && head.valid;
    load_out = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  end

  // multiplier operand select per command and step
  always_comb begin
    opa = e_r.am;
    opb = e_r.bdm;
    case (step_r)
      2'd0: begin
        opa = e_r.am;
        opb = (e_r.cmd == CMD_MUL) ? e_r.bm : e_r.bdm;
      end
      2'd1: begin
        opa = (e_r.cmd == CMD_MUL) ? e_r.adm : e_r.bm;
        opb = (e_r.cmd == CMD_MUL) ? e_r.bdm : e_r.adm;
      end
      default: begin
        opa = e_r.adm;
        opb = e_r.bdm;
      end
    endcase
  end
  assign prod = opa * opb;

  // signed cross products for comparison
  assign xs = e_r.sa ? (64'd0 - p_r[0]) : p_r[0];
  assign ys = e_r.sb ? (64'd0 - p_r[1]) : p_r[1];
  assign s2 = (e_r.cmd == CMD_SUB) ? (!e_r.sb && e_r.b_nz) : e_r.sb;

  // restoring division trial
  assign tn = {remn_r, qn_r[63]};
  assign td = {remd_r, qd_r[63]};

  // range check of reduced result
  assign fin_rs = rs_r && (qn_r != 64'd0);
  assign ovf    = (qd_r > LIM - 64'd1) || (qn_r > (fin_rs ? LIM : LIM - 64'd1));

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      e_r    <= head.data;
      step_r <= 2'd0;
    end
    if (state_r == ST_MUL) begin
      p_r[step_r] <= prod;
      step_r      <= step_r + 2'd1;
    end
    if (state_r == ST_COMB) begin
      case (e_r.cmd)
        CMD_GT: cmp_r <= $signed(xs) > $signed(ys);
        CMD_GE: cmp_r <= $signed(xs) >= $signed(ys);
        CMD_EQ: cmp_r <= (xs == ys);
        default: cmp_r <= 1'b0;
      endcase
      case (e_r.cmd) inside
        CMD_ADD, CMD_SUB: begin
          rd_r <= p_r[2];
          if (e_r.sa == s2) begin
            rm_r <= p_r[0] + p_r[1];
            rs_r <= e_r.sa;
          end else if (p_r[0] >= p_r[1]) begin
            rm_r <= p_r[0] - p_r[1];
            rs_r <= e_r.sa;
          end else begin
            rm_r <= p_r[1] - p_r[0];
            rs_r <= s2;
          end
        end
        CMD_MUL, CMD_DIV: begin
          rm_r <= p_r[0];
          rd_r <= p_r[1];
          rs_r <= e_r.sa != e_r.sb;
        end
        default: begin
          rm_r <= {32'd0, e_r.am};
          rd_r <= {32'd0, e_r.adm};
          rs_r <= e_r.sa;
        end
      endcase
      k_r <= 6'd0;
    end
    if (state_r == ST_COMB) begin
      case (e_r.cmd) inside
        CMD_ADD, CMD_SUB: begin
          gy_r <= p_r[2];
          if (e_r.sa == s2)            gx_r <= p_r[0] + p_r[1];
          else if (p_r[0] >= p_r[1])   gx_r <= p_r[0] - p_r[1];
          else                         gx_r <= p_r[1] - p_r[0];
        end
        CMD_MUL, CMD_DIV: begin
          gx_r <= p_r[0];
          gy_r <= p_r[1];
        end
        default: begin
          gx_r <= {32'd0, e_r.am};
          gy_r <= {32'd0, e_r.adm};
        end
      endcase
    end
    // binary gcd step
    if (state_r == ST_GCD) begin
      if (gx_r == 64'd0) begin
        g_r    <= gy_r << k_r;
        qn_r   <= rm_r;
        qd_r   <= rd_r;
        remn_r <= 64'd0;
        remd_r <= 64'd0;
        cnt_r  <= 6'd0;
      end else if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        k_r  <= k_r + 6'd1;
      end else if (!gx_r[0]) begin
        gx_r <= gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_r <= gy_r >> 1;
      end else if (gx_r >= gy_r) begin
        gx_r <= gx_r - gy_r;
      end else begin
        gy_r <= gy_r - gx_r;
      end
    end
    // one quotient bit of each division per cycle
    if (state_r == ST_DIV) begin
      if (tn >= {1'b0, g_r}) begin
        remn_r <= 64'(tn - {1'b0, g_r});
        qn_r   <= {qn_r[62:0], 1'b1};
      end else begin
        remn_r <= tn[63:0];
        qn_r   <= {qn_r[62:0], 1'b0};
      end
      if (td >= {1'b0, g_r}) begin
        remd_r <= 64'(td - {1'b0, g_r});
        qd_r   <= {qd_r[62:0], 1'b1};
      end else begin
        remd_r <= td[63:0];
        qd_r   <= {qd_r[62:0], 1'b0};
      end
      cnt_r <= cnt_r + 6'd1;
    end
    // result word
    if (load_out) begin
      res_num_r  <= 32'd0;
      res_den_r  <= 31'd0;
      cmp_true_r <= 1'b0;
      if (e_r.err) begin
        status_r <= STAT_ZDEN;
      end else if (e_r.cmd == CMD_GT || e_r.cmd == CMD_GE || e_r.cmd == CMD_EQ) begin
        status_r   <= STAT_OK;
        cmp_true_r <= cmp_r;
      end else if (ovf) begin
        status_r <= STAT_OVF;
      end else begin
        status_r  <= STAT_OK;
        res_num_r <= fin_rs ? (32'd0 - qn_r[31:0]) : qn_r[31:0];
        res_den_r <= qd_r[30:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.res_num  = res_num_r;
  assign out_ch.res_den  = res_den_r;
  assign out_ch.cmp_true = cmp_true_r;
  assign out_ch.status   = status_r;
endmodule
`default_nettype wire

[src/rational_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Adds, subtracts, multiplies, divides, compares or reduces fractions.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   cmd, a_num, a_den, b_num, b_den
//  out_ch   out  res_num, res_den, cmp_true, status
//
//  A word passes through the back end in order: dequeue, three products on
//  one 32x32 multiplier, combine, binary gcd steps, two parallel divisions
//  and the result word.
//  Zero-denominator words skip to the result; compares skip gcd and divide.
//  The front queue holds two words so input is taken while the back works.
//  Reset clears the queue and state machine; a stalled result holds.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_core #(
  parameter int WORD_BITS = 32
) (
  input  wire       clk,
  input  wire       rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  q_head_t head;
  logic    pop;

  rau_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  rau_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule
`default_nettype wire
